// ===== rtl/dda_line_rasterizer_defines.svh =====
// Assertion macros used by the checker file of the line rasterizer.
`ifndef DDA_LINE_RASTERIZER_DEFINES_SVH
`define DDA_LINE_RASTERIZER_DEFINES_SVH

// Checked property, off while reset is asserted.
`define DLR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dda_line_rasterizer assertion failed");

// Checked property, also active during reset.
`define DLR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dda_line_rasterizer assertion failed");

`endif

// ===== rtl/dlr_pkg.sv =====
// Package: shared widths, command record and walker state type.
`timescale 1ns / 1ps
package dlr_pkg;

  localparam int COORD_W            = 6;
  localparam int GLYPH_W            = 8;
  localparam int COORD_BITS_DEFAULT = 6;
  localparam int QUEUE_DEPTH        = 2;

  // Classified line command, major/minor form, ascending along major axis.
  typedef struct packed {
    logic               col_major;
    logic               neg;       // minor coordinate decreases
    logic [COORD_W-1:0] maj0;
    logic [COORD_W-1:0] min0;
    logic [COORD_W-1:0] dmaj;
    logic [COORD_W-1:0] amin;
    logic [GLYPH_W-1:0] glyph;
  } line_cmd_t;

  typedef enum logic {
    WALK_IDLE,
    WALK_RUN
  } walk_state_t;

endpackage

// ===== rtl/dlr_front.sv =====
// Front end: accepts line commands, picks major axis, orders endpoints.
`timescale 1ns / 1ps
module dlr_front import dlr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [COORD_W-1:0] row_start,
  input  logic [COORD_W-1:0] col_start,
  input  logic [COORD_W-1:0] row_end,
  input  logic [COORD_W-1:0] col_end,
  input  logic [GLYPH_W-1:0] glyph,
  input  logic               q_full,
  output logic               q_push,
  output line_cmd_t          q_cmd
);

  localparam int N = COORD_BITS;

  logic [N-1:0] r0, c0, r1, c1;
  logic [N-1:0] adr, adc;
  logic         col_major;
  logic         swap;

  assign r0 = row_start[N-1:0];
  assign c0 = col_start[N-1:0];
  assign r1 = row_end[N-1:0];
  assign c1 = col_end[N-1:0];

  assign adr       = (r1 >= r0) ? (r1 - r0) : (r0 - r1);
  assign adc       = (c1 >= c0) ? (c1 - c0) : (c0 - c1);
  assign col_major = (adc >= adr);   // ties walk along columns

  always_comb begin
    q_cmd           = '0;
    q_cmd.col_major = col_major;
    q_cmd.glyph     = glyph;
    if (col_major) begin
      swap       = (c0 > c1);
      q_cmd.maj0 = COORD_W'(swap ? c1 : c0);
      q_cmd.min0 = COORD_W'(swap ? r1 : r0);
      q_cmd.dmaj = COORD_W'(adc);
      q_cmd.amin = COORD_W'(adr);
      q_cmd.neg  = swap ? (r1 > r0) : (r1 < r0);
    end else begin
      swap       = (r0 > r1);
      q_cmd.maj0 = COORD_W'(swap ? r1 : r0);
      q_cmd.min0 = COORD_W'(swap ? c1 : c0);
      q_cmd.dmaj = COORD_W'(adr);
      q_cmd.amin = COORD_W'(adc);
      q_cmd.neg  = swap ? (c1 > c0) : (c1 < c0);
    end
  end

  // zero-length lines are consumed without entering the queue
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && (q_cmd.dmaj != '0);

endmodule

// ===== rtl/dlr_queue.sv =====
// Short command queue between front end and line walker.
`timescale 1ns / 1ps
module dlr_queue import dlr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  line_cmd_t wdata,
  input  logic      pop,
  output line_cmd_t rdata,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  line_cmd_t          entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/dlr_walker.sv =====
// Line walker: steps the major axis, tracks minor with an error term.
`timescale 1ns / 1ps
module dlr_walker import dlr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  line_cmd_t          q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COORD_W-1:0] cell_row,
  output logic [COORD_W-1:0] cell_col,
  output logic [GLYPH_W-1:0] cell_glyph,
  output logic               last_cell
);

  localparam int N = COORD_BITS;

  walk_state_t state, state_next;

  logic               col_major;
  logic               neg;
  logic [N-1:0]       maj;
  logic [N-1:0]       min0;
  logic [N-1:0]       dmaj;
  logic [N-1:0]       amin;
  logic [N-1:0]       cnt;     // cells still to emit
  logic [N-1:0]       quo;
  logic [N-1:0]       rem;
  logic [GLYPH_W-1:0] glyph_r;

  logic         out_free;
  logic         step;
  logic         load;
  logic [N:0]   rem_sum;
  logic         wrap;
  logic [N-1:0] minor;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      WALK_IDLE: if (!q_empty) state_next = WALK_RUN;
      WALK_RUN:  if (out_free && (cnt == N'(1))) state_next = WALK_IDLE;
      default:   state_next = WALK_IDLE;
    endcase
  end

  always_comb begin
    load = 1'b0;
    step = 1'b0;
    case (state)
      WALK_IDLE: load = !q_empty;
      WALK_RUN:  step = out_free;
      default: begin
        load = 1'b0;
        step = 1'b0;
      end
    endcase
  end

  assign q_pop = load;

  // amin <= dmaj, so one conditional subtract keeps rem below dmaj
  assign rem_sum = {1'b0, rem} + {1'b0, amin};
  assign wrap    = (rem_sum >= {1'b0, dmaj});
  assign minor   = neg ? (min0 - quo - N'(rem != '0)) : (min0 + quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= WALK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      col_major <= q_cmd.col_major;
      neg       <= q_cmd.neg;
      maj       <= q_cmd.maj0[N-1:0];
      min0      <= q_cmd.min0[N-1:0];
      dmaj      <= q_cmd.dmaj[N-1:0];
      amin      <= q_cmd.amin[N-1:0];
      cnt       <= q_cmd.dmaj[N-1:0];
      glyph_r   <= q_cmd.glyph;
      quo       <= '0;
      rem       <= '0;
    end else if (step) begin
      maj <= maj + 1'b1;
      cnt <= cnt - 1'b1;
      if (wrap) begin
        quo <= quo + 1'b1;
        rem <= N'(rem_sum - {1'b0, dmaj});
      end else begin
        rem <= N'(rem_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      cell_row   <= COORD_W'(col_major ? minor : maj);
      cell_col   <= COORD_W'(col_major ? maj : minor);
      cell_glyph <= glyph_r;
      last_cell  <= (cnt == N'(1));
    end
  end

endmodule

// ===== rtl/dda_line_rasterizer.sv =====
// Top level of the DDA line rasterizer: front end, queue, line walker.
`timescale 1ns / 1ps
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  command  | in_valid / in_stall | row_start col_start row_end col_end glyph
//  cell     | out_valid/out_stall | cell_row cell_col cell_glyph last_cell
//
// A line of major length D gives D cells, one per cycle while the cell side
// keeps taking them; between lines the walker goes back to idle to pull the
// next command from the queue.
// Commands are taken while the two-entry queue has room.
// Equal endpoints are taken and produce no cells.
// Synchronous reset empties the queue and clears out_valid.
// out_stall only holds the walker; in_stall rises only when the queue is full.
//
module dda_line_rasterizer import dlr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [COORD_W-1:0] row_start,
  input  logic [COORD_W-1:0] col_start,
  input  logic [COORD_W-1:0] row_end,
  input  logic [COORD_W-1:0] col_end,
  input  logic [GLYPH_W-1:0] glyph,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COORD_W-1:0] cell_row,
  output logic [COORD_W-1:0] cell_col,
  output logic [GLYPH_W-1:0] cell_glyph,
  output logic               last_cell
);

  // front end -> queue
  logic      q_push;
  line_cmd_t q_wdata;
  logic      q_full;
  // queue -> walker
  logic      q_pop;
  line_cmd_t q_rdata;
  logic      q_empty;

  // Classify: major axis, ascending order, |minor delta| and its direction.
  dlr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .row_start (row_start),
    .col_start (col_start),
    .row_end   (row_end),
    .col_end   (col_end),
    .glyph     (glyph),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_wdata)
  );

  // Decouples command intake from cell output.
  dlr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // One cell per cycle unless stalled; minor = min0 + floor(amin*k/D) (neg: min0 - ceil) via quo/rem.
  dlr_walker #(
    .COORD_BITS(COORD_BITS)
  ) u_walker (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_cmd      (q_rdata),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_row   (cell_row),
    .cell_col   (cell_col),
    .cell_glyph (cell_glyph),
    .last_cell  (last_cell)
  );

endmodule

// ===== rtl/dlr_checker.sv =====
// Port-level checker for the line rasterizer, bound to the top level.
`timescale 1ns / 1ps
`include "dda_line_rasterizer_defines.svh"
module dlr_checker import dlr_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [COORD_W-1:0] cell_row,
  input logic [COORD_W-1:0] cell_col,
  input logic [GLYPH_W-1:0] cell_glyph,
  input logic               last_cell
);

  // stalled cell holds
  `DLR_ASSERT(a_out_hold,
    out_valid && out_stall |=> out_valid && $stable(cell_row) && $stable(cell_col)
      && $stable(cell_glyph) && $stable(last_cell))

  // reset leaves no cell pending and the queue open
  `DLR_ASSERT_ALWAYS(a_rst_clear, $past(rst) |-> !out_valid && !in_stall)

  // back-to-back cells of one line share the glyph
  `DLR_ASSERT(a_same_glyph,
    out_valid && !out_stall && !last_cell ##1 out_valid |-> cell_glyph == $past(cell_glyph))

  // back-to-back cells of one line advance one step on some axis
  `DLR_ASSERT(a_major_step,
    out_valid && !out_stall && !last_cell ##1 out_valid |->
      (cell_col == COORD_W'($past(cell_col) + 1'b1))
      || (cell_row == COORD_W'($past(cell_row) + 1'b1)))

endmodule

bind dda_line_rasterizer dlr_checker u_dlr_checker (.*);
